### rtl/podo_pkg.sv
// Shared constants and types for the position odometer.
// No dependencies; every other file of the block uses this package.
package podo_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int SUM_BITS_DEF   = 48;

  localparam int CFG_BITS   = 16;
  localparam int INDEX_BITS = 2;
  localparam int STEP_BITS  = 25;
  localparam int TICK_BITS  = 16;
  localparam int SCALE_FRAC = 8;

  localparam logic REQ_FIX  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [INDEX_BITS-1:0] REG_STALE_LIMIT     = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_DEPTH_THRESHOLD = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_DISTANCE_SCALE  = 2'd2;

  localparam logic [CFG_BITS-1:0] STALE_LIMIT_RST     = 16'd10;
  localparam logic [CFG_BITS-1:0] DEPTH_THRESHOLD_RST = 16'd0;
  localparam logic [CFG_BITS-1:0] DISTANCE_SCALE_RST  = 16'd256;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

### rtl/podo_if.sv
// Handshake channels of the position odometer: items, results, register writes.
// Depends on podo_pkg.
interface podo_item_if #(
  parameter int COORD_BITS = podo_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] x_position;
  logic signed [COORD_BITS-1:0] y_position;
  logic [podo_pkg::CFG_BITS-1:0] depth_now;

  modport source (output valid, req_type, x_position, y_position, depth_now, input ready);
  modport sink   (input valid, req_type, x_position, y_position, depth_now, output ready);
endinterface

interface podo_result_if #(
  parameter int SUM_BITS = podo_pkg::SUM_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [SUM_BITS-1:0]            scaled_total;
  logic [SUM_BITS-1:0]            deep_total;
  logic [podo_pkg::STEP_BITS-1:0] step_length;
  logic                           stale_flag;

  modport source (output valid, scaled_total, deep_total, step_length, stale_flag,
                  input ready);
  modport sink   (input valid, scaled_total, deep_total, step_length, stale_flag,
                  output ready);
endinterface

interface podo_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [podo_pkg::INDEX_BITS-1:0] index;
  logic [podo_pkg::CFG_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/position_odometer.sv
// Position odometer: each fix after the first adds floor(sqrt(dx^2 + dy^2)) to a
// distance total and, when depth gating allows, to a deep total; ticks age a
// stale counter. One item is worked at a time. A tick goes from acceptance
// through the serial scaler and a finishing state into the output register.
// A fix with a previous fix goes through the serial squarer, the bit-serial
// square root and the scaler, with steps between them that hand over to the
// root, latch the root, accumulate, finish and load the output register. A
// first fix takes the tick path. The next item is taken as soon as the
// previous result sits in the output register; while the receiver holds that
// result, the next finished result and the input wait. Depends on podo_pkg,
// podo_if, podo_sqmul, podo_sqrt and podo_scale.
module position_odometer #(
  parameter int COORD_BITS = podo_pkg::COORD_BITS_DEF,
  parameter int SUM_BITS   = podo_pkg::SUM_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  podo_item_if.sink       item,
  podo_result_if.source   result,
  podo_cfg_if.sink        cfg
);

  localparam int C  = COORD_BITS;
  localparam int SW = COORD_BITS + 1;
  localparam int SB = SUM_BITS;
  localparam int CB = podo_pkg::CFG_BITS;
  localparam int TB = podo_pkg::TICK_BITS;
  localparam int ST = podo_pkg::STEP_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQUARE = 6'b000010,
    S_ROOT   = 6'b000100,
    S_ACCUM  = 6'b001000,
    S_SCALE  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CB-1:0] stale_limit;
  logic [CB-1:0] depth_threshold;
  logic [CB-1:0] distance_scale;

  logic                have_previous;
  logic signed [C-1:0] last_x;
  logic signed [C-1:0] last_y;
  logic [SB-1:0]       distance_sum;
  logic [SB-1:0]       deep_sum;
  logic                fix_seen;
  logic [TB-1:0]       ticks_since_fix;
  logic                warning_on;
  logic                deep_gate;
  logic [SW-1:0]       step;

  logic [SB-1:0]       scaled_total;
  logic [SB-1:0]       deep_total;
  logic [ST-1:0]       step_length;
  logic                stale_flag;
  logic                out_valid;

  logic                accept;
  logic                is_fix;
  logic signed [C:0]   dx;
  logic signed [C:0]   dy;
  logic [C:0]          ax;
  logic [C:0]          ay;
  logic [TB-1:0]       ticks_next;
  logic [SB:0]         dist_add;
  logic [SB:0]         deep_add;
  logic [SB-1:0]       distance_sum_next;
  logic [SB-1:0]       deep_sum_next;
  logic [SW+ST-1:0]    step_ext;
  logic                out_free;

  logic                sq_start;
  logic [2*C:0]        sum_sq;
  logic                rt_start;
  logic [SW-1:0]       root;
  logic                sc_start;
  logic [SB-1:0]       sc_total;
  logic [SB-1:0]       scaled;

  podo_pkg::unit_status_t sq_stat;
  podo_pkg::unit_status_t rt_stat;
  podo_pkg::unit_status_t sc_stat;

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign is_fix     = (item.req_type == podo_pkg::REQ_FIX);
  assign out_free   = !out_valid || result.ready;

  always_comb begin
    dx = {item.x_position[C-1], item.x_position} - {last_x[C-1], last_x};
    dy = {item.y_position[C-1], item.y_position} - {last_y[C-1], last_y};
    ax = dx[C] ? -dx : dx;
    ay = dy[C] ? -dy : dy;
    ticks_next = (ticks_since_fix == {TB{1'b1}}) ? ticks_since_fix
                                                 : ticks_since_fix + TB'(1);
    dist_add = {1'b0, distance_sum} + {{(SB-SW+1){1'b0}}, step};
    deep_add = {1'b0, deep_sum} + {{(SB-SW+1){1'b0}}, step};
    distance_sum_next = dist_add[SB] ? {SB{1'b1}} : dist_add[SB-1:0];
    deep_sum_next     = deep_add[SB] ? {SB{1'b1}} : deep_add[SB-1:0];
    step_ext = {{ST{1'b0}}, step};
  end

  assign sq_start = accept && is_fix && have_previous;
  assign rt_start = (state == S_SQUARE) && sq_stat.done;
  assign sc_start = (accept && !(is_fix && have_previous)) || (state == S_ACCUM);
  assign sc_total = (state == S_ACCUM) ? distance_sum_next : distance_sum;

  podo_sqmul #(.W(C)) u_sqmul (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .a      (ax[C-1:0]),
    .b      (ay[C-1:0]),
    .sum_sq (sum_sq),
    .status (sq_stat)
  );

  podo_sqrt #(.Q(SW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (sum_sq),
    .root     (root),
    .status   (rt_stat)
  );

  podo_scale #(.SB(SB)) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (sc_start),
    .total  (sc_total),
    .scale  (distance_scale),
    .scaled (scaled),
    .status (sc_stat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = sq_start ? S_SQUARE : S_SCALE;
        end
      end
      S_SQUARE: begin
        if (sq_stat.done) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (rt_stat.done) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        state_next = S_SCALE;
      end
      S_SCALE: begin
        if (sc_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      stale_limit     <= podo_pkg::STALE_LIMIT_RST;
      depth_threshold <= podo_pkg::DEPTH_THRESHOLD_RST;
      distance_scale  <= podo_pkg::DISTANCE_SCALE_RST;
      have_previous   <= 1'b0;
      last_x          <= '0;
      last_y          <= '0;
      distance_sum    <= '0;
      deep_sum        <= '0;
      fix_seen        <= 1'b0;
      ticks_since_fix <= '0;
      warning_on      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          podo_pkg::REG_STALE_LIMIT:     stale_limit     <= cfg.data;
          podo_pkg::REG_DEPTH_THRESHOLD: depth_threshold <= cfg.data;
          podo_pkg::REG_DISTANCE_SCALE:  distance_scale  <= cfg.data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (is_fix) begin
          have_previous   <= 1'b1;
          last_x          <= item.x_position;
          last_y          <= item.y_position;
          fix_seen        <= 1'b1;
          ticks_since_fix <= '0;
          warning_on      <= (stale_limit == '0);
        end else begin
          ticks_since_fix <= ticks_next;
          if (fix_seen) begin
            warning_on <= (ticks_next >= stale_limit);
          end
        end
      end
      if (state == S_ACCUM) begin
        distance_sum <= distance_sum_next;
        if (deep_gate) begin
          deep_sum <= deep_sum_next;
        end
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step      <= '0;
      deep_gate <= (depth_threshold == '0) || (item.depth_now > depth_threshold);
    end else if (state == S_ROOT && rt_stat.done) begin
      step <= root;
    end
    if (state == S_DONE && out_free) begin
      scaled_total <= scaled;
      deep_total   <= deep_sum;
      step_length  <= step_ext[ST-1:0];
      stale_flag   <= warning_on;
    end
  end

  assign result.valid        = out_valid;
  assign result.scaled_total = scaled_total;
  assign result.deep_total   = deep_total;
  assign result.step_length  = step_length;
  assign result.stale_flag   = stale_flag;

  a_tick_skips_root: assert property (@(posedge clk) disable iff (rst)
    accept && item.req_type == podo_pkg::REQ_TICK |=> state == S_SCALE && step == '0)
    else $error("tick did not go straight to scaling with a zero step");

  a_deep_bounded: assert property (@(posedge clk) disable iff (rst)
    deep_sum <= distance_sum)
    else $error("deep total exceeds distance total");

  a_square_done_in_state: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> state == S_SQUARE && !rt_stat.busy)
    else $error("squarer finished outside its state");

  a_scale_start_idle: assert property (@(posedge clk) disable iff (rst)
    sc_start |-> !sc_stat.busy && !sq_stat.busy && !rt_stat.busy)
    else $error("scaler started while a unit was busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> out_valid && state == S_IDLE)
    else $error("finished result not presented");

endmodule

### rtl/podo_sqmul.sv
// Serial shift-and-add unit: a*a + b*b, one multiplier bit per cycle.
// Depends on podo_pkg.
module podo_sqmul #(
  parameter int W = podo_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [W-1:0]           a,
  input  logic [W-1:0]           b,
  output logic [2*W:0]           sum_sq,
  output podo_pkg::unit_status_t status
);

  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] mcand;
  logic [W-1:0]   mplier;
  logic [W-1:0]   second;
  logic [2*W:0]   acc;
  logic [CW-1:0]  cnt;
  logic           phase;
  logic           busy;
  logic           done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1) && phase) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= {{W{1'b0}}, a};
      mplier <= a;
      second <= b;
      acc    <= '0;
      cnt    <= CW'(W);
      phase  <= 1'b0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + {1'b0, mcand};
      end
      if (cnt == CW'(1) && !phase) begin
        mcand  <= {{W{1'b0}}, second};
        mplier <= second;
        cnt    <= CW'(W);
        phase  <= 1'b1;
      end else begin
        mcand  <= {mcand[2*W-2:0], 1'b0};
        mplier <= {1'b0, mplier[W-1:1]};
        cnt    <= cnt - CW'(1);
      end
    end
  end

  assign sum_sq      = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### rtl/podo_sqrt.sv
// Restoring integer square root, one root bit (two radicand bits) per cycle.
// Depends on podo_pkg.
module podo_sqrt #(
  parameter int Q = podo_pkg::COORD_BITS_DEF + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*Q-2:0]         radicand,
  output logic [Q-1:0]           root,
  output podo_pkg::unit_status_t status
);

  localparam int N  = 2 * Q;
  localparam int CW = $clog2(Q + 1);

  logic [N-1:0]  rad;
  logic [Q+1:0]  rem;
  logic [Q-1:0]  res;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [Q+1:0]  rem_sh;
  logic [Q+1:0]  trial;
  logic          fits;

  always_comb begin
    rem_sh = {rem[Q-1:0], rad[N-1:N-2]};
    trial  = {res, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= {1'b0, radicand};
      rem <= '0;
      res <= '0;
      cnt <= CW'(Q);
    end else if (busy) begin
      rad <= {rad[N-3:0], 2'b00};
      rem <= fits ? (rem_sh - trial) : rem_sh;
      res <= {res[Q-2:0], fits};
      cnt <= cnt - CW'(1);
    end
  end

  assign root        = res;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### rtl/podo_scale.sv
// Serial Q8.8 scaler: total times scale, one scale bit per cycle, MSB first,
// then drop the fraction and saturate. Depends on podo_pkg.
module podo_scale #(
  parameter int SB = podo_pkg::SUM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [SB-1:0]                   total,
  input  logic [podo_pkg::CFG_BITS-1:0]   scale,
  output logic [SB-1:0]                   scaled,
  output podo_pkg::unit_status_t          status
);

  localparam int S  = podo_pkg::CFG_BITS;
  localparam int F  = podo_pkg::SCALE_FRAC;
  localparam int CW = $clog2(S + 1);

  logic [SB+S-1:0] acc;
  logic [SB-1:0]   operand;
  logic [S-1:0]    sbits;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic            done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= '0;
      operand <= total;
      sbits   <= scale;
      cnt     <= CW'(S);
    end else if (busy) begin
      acc   <= {acc[SB+S-2:0], 1'b0} + (sbits[S-1] ? {{S{1'b0}}, operand} : '0);
      sbits <= {sbits[S-2:0], 1'b0};
      cnt   <= cnt - CW'(1);
    end
  end

  assign scaled      = (acc[SB+S-1:SB+F] != '0) ? {SB{1'b1}} : acc[SB+F-1:F];
  assign status.busy = busy;
  assign status.done = done;

endmodule
